### src/mstt_pkg.sv
// Shared types and constants for the multi-slot task timer.
package mstt_pkg;

    localparam int MAX_RES = 8;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_ADD      = 3'd1,
        MODE_ADD_PRE  = 3'd2,
        MODE_PAUSE    = 3'd3,
        MODE_CONTINUE = 3'd4,
        MODE_DISABLE  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OFF   = 3'd0,
        ST_ON    = 3'd1,
        ST_ADD   = 3'd2,
        ST_PAUSE = 3'd3,
        ST_TOOFF = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_CONT   = 2'd1,
        KIND_PRE    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] period;
        logic [15:0] count;
        logic [15:0] predelay;
    } t_entry;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TRD   = 8'b0000_0010,
        S_TEX   = 8'b0000_0100,
        S_TEND  = 8'b0000_1000,
        S_FIND  = 8'b0001_0000,
        S_DIV1  = 8'b0010_0000,
        S_DIV2  = 8'b0100_0000,
        S_REPLY = 8'b1000_0000
    } t_state;

endpackage

### src/multi_slot_task_timer.sv
// Multi-slot task timer: slot table, command sequencer and shared adder/divider.
//
// Input channel (s_axis): one command per transaction; tuser carries the mode
// (tick, add, add with predelay, pause, continue, disable), tdata the operands.
// Output channel (m_axis): result transactions; tuser is the event kind
// (expiry or add reply), tdata the slot and full flag, tlast marks the final
// result of a command. Ticks without expiry and slot commands give none.
// Configuration: i_cfg_we writes the tick period in ms from i_cfg_data.
// Throughput: one command at a time; s_axis_tready is high only when idle.
// Every command is accepted in idle; pause, continue and disable need nothing
// more. A tick then reads each slot in turn, steps each running slot and
// closes with the tick end, bound by the single read port of
// the slot memory and the one shared adder. An add then searches for a free
// slot, divides on the shared adder (one quotient bit per cycle, twice with
// predelay) unless the table is full, and sends one reply.
// A stalled receiver holds the sequencer only when a new result must leave
// while the output register is still full.
// Reset clears the slot status, marks all slot entries unwritten (they read
// as zero) and sets the tick period to 1; no clearing pass is needed.
module multi_slot_task_timer
    import mstt_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot_sel[2:0], interval_ms[18:3], predelay_ms[34:19], repeat_kind[35], zero pad
    input  logic [39:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_out[2:0], table_full[3], zero pad
    output logic [7:0]  m_axis_tdata,
    // event_kind[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state        r_state, n_state;
    logic [7:0]    r_tick;
    t_status       r_status [SLOTS];
    logic          r_wr [SLOTS];
    t_entry        r_mem [SLOTS];
    t_entry        r_rd;
    logic          r_rd_wr;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_slot;
    logic          r_full;
    logic          r_is_pre;
    t_kind         r_kind;
    logic [15:0]   r_ival;
    logic [15:0]   r_pdly;
    logic [15:0]   r_period;
    logic [15:0]   r_pre;
    logic [7:0]    r_rem;
    logic [15:0]   r_quo;
    logic [3:0]    r_dcnt;
    logic [3:0]    r_nres;
    logic          r_hold_v;
    logic [2:0]    r_hold_slot;
    logic          r_out_valid;
    logic [2:0]    r_out_slot;
    logic          r_out_full;
    logic          r_out_kind;
    logic          r_out_last;

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_out_load;
    logic          w_last_idx;
    logic [7:0]    w_div;
    t_entry        w_entry;
    logic          w_is_pre;
    logic [15:0]   w_a;
    logic [15:0]   w_b;
    logic          w_cin;
    logic [16:0]   w_sum;
    logic [8:0]    w_rem_sh;
    logic          w_ge;
    logic [7:0]    n_rem;
    logic [15:0]   n_quo;
    logic [15:0]   w_res;
    logic          w_hit;
    logic          w_pre_zero;
    logic          w_emit;
    logic          w_stall;
    logic          w_mem_we;
    logic [IW-1:0] w_mem_addr;
    t_entry        w_mem_wdata;
    logic [IW-1:0] w_sel_idx;
    logic          w_sel_ok;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_last_idx    = (r_idx == IW'(SLOTS - 1));
    assign w_div         = (r_tick == 8'd0) ? 8'd1 : r_tick;
    assign w_sel_idx     = IW'(s_axis_tdata[2:0]);
    assign w_sel_ok      = (7'(s_axis_tdata[2:0]) < 7'(SLOTS));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_full, r_out_slot};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    assign w_entry  = r_rd_wr ? r_rd : '0;
    assign w_is_pre = (w_entry.kind == KIND_PRE);
    assign w_rem_sh = {r_rem, r_quo[15]};

    // shared adder: count increment or predelay decrement on ticks, trial subtract while dividing
    always_comb begin
        if (r_state == S_TEX) begin
            w_a   = w_is_pre ? w_entry.predelay : w_entry.count;
            w_b   = w_is_pre ? 16'hFFFF : 16'h0000;
            w_cin = !w_is_pre;
        end else begin
            w_a   = {7'b0, w_rem_sh};
            w_b   = ~{8'b0, w_div};
            w_cin = 1'b1;
        end
    end

    assign w_sum      = {1'b0, w_a} + {1'b0, w_b} + 17'(w_cin);
    assign w_ge       = w_sum[16];
    assign n_rem      = w_ge ? w_sum[7:0] : w_rem_sh[7:0];
    assign n_quo      = {r_quo[14:0], w_ge};
    assign w_res      = w_sum[15:0];
    assign w_hit      = !w_is_pre && (w_res == w_entry.period);
    assign w_pre_zero = w_is_pre && (w_res == 16'h0000);
    assign w_emit     = w_hit && (r_nres < 4'(MAX_RES));
    assign w_stall    = w_emit && r_hold_v && !w_out_free;
    assign w_out_load = w_out_free && (((r_state == S_TEX) && w_emit && r_hold_v)
                                       || ((r_state == S_TEND) && r_hold_v)
                                       || (r_state == S_REPLY));

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = r_idx;
        w_mem_wdata = w_entry;
        if (r_state == S_TEX) begin
            w_mem_we             = !w_stall;
            w_mem_wdata.count    = w_is_pre ? w_entry.count : (w_hit ? 16'h0000 : w_res);
            w_mem_wdata.predelay = w_is_pre ? w_res : w_entry.predelay;
            w_mem_wdata.kind     = w_pre_zero ? KIND_CONT : w_entry.kind;
        end else if (r_state == S_REPLY) begin
            w_mem_we    = w_out_free && !r_full;
            w_mem_addr  = r_slot;
            w_mem_wdata = '{kind: r_kind, period: r_period, count: 16'h0000,
                            predelay: r_pre};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (s_axis_tuser)
                        MODE_TICK:                n_state = S_TRD;
                        MODE_ADD, MODE_ADD_PRE:   n_state = S_FIND;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_TRD: begin
                if (r_status[r_idx] == ST_ON) begin
                    n_state = S_TEX;
                end else if (w_last_idx) begin
                    n_state = S_TEND;
                end
            end
            S_TEX: begin
                if (!w_stall) begin
                    n_state = w_last_idx ? S_TEND : S_TRD;
                end
            end
            S_TEND: begin
                if (!r_hold_v || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_status[r_idx] == ST_OFF) begin
                    n_state = S_DIV1;
                end else if (w_last_idx) begin
                    n_state = S_REPLY;
                end
            end
            S_DIV1: begin
                if (r_dcnt == 4'd15) begin
                    n_state = r_is_pre ? S_DIV2 : S_REPLY;
                end
            end
            S_DIV2: begin
                if (r_dcnt == 4'd15) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= 8'd1;
            r_out_valid <= 1'b0;
            r_hold_v    <= 1'b0;
            r_idx       <= '0;
            r_nres      <= 4'd0;
            r_dcnt      <= 4'd0;
            r_rd_wr     <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_OFF;
                r_wr[i]     <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_rd_wr <= r_wr[r_idx];
            if (i_cfg_we) begin
                r_tick <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_idx    <= '0;
                        r_nres   <= 4'd0;
                        r_hold_v <= 1'b0;
                        r_ival   <= s_axis_tdata[18:3];
                        r_pdly   <= s_axis_tdata[34:19];
                        r_is_pre <= (s_axis_tuser == MODE_ADD_PRE);
                        r_kind   <= (s_axis_tuser == MODE_ADD_PRE) ? KIND_PRE
                                  : t_kind'({1'b0, s_axis_tdata[35]});
                        r_pre    <= 16'h0000;
                        if (w_sel_ok) begin
                            case (s_axis_tuser)
                                MODE_PAUSE: r_status[w_sel_idx] <= ST_PAUSE;
                                MODE_CONTINUE: begin
                                    if (r_status[w_sel_idx] == ST_PAUSE) begin
                                        r_status[w_sel_idx] <= ST_ON;
                                    end
                                end
                                MODE_DISABLE: r_status[w_sel_idx] <= ST_TOOFF;
                                default: ;
                            endcase
                        end
                    end
                end
                S_TRD: begin
                    if (r_status[r_idx] != ST_ON && !w_last_idx) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_TEX: begin
                    if (!w_stall) begin
                        r_wr[r_idx] <= 1'b1;
                        if (w_pre_zero) begin
                            r_status[r_idx] <= ST_ADD;
                        end
                        if (w_hit && w_entry.kind == KIND_SINGLE) begin
                            r_status[r_idx] <= ST_OFF;
                        end
                        if (w_emit) begin
                            if (r_hold_v) begin
                                r_out_valid <= 1'b1;
                                r_out_slot  <= r_hold_slot;
                                r_out_full  <= 1'b0;
                                r_out_kind  <= 1'b0;
                                r_out_last  <= 1'b0;
                            end
                            r_hold_v    <= 1'b1;
                            r_hold_slot <= 3'(r_idx);
                            r_nres      <= r_nres + 4'd1;
                        end
                        if (!w_last_idx) begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_TEND: begin
                    if (!r_hold_v || w_out_free) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_status[i] == ST_TOOFF) begin
                                r_status[i] <= ST_OFF;
                            end else if (r_status[i] == ST_ADD) begin
                                r_status[i] <= ST_ON;
                            end
                        end
                        if (r_hold_v) begin
                            r_out_valid <= 1'b1;
                            r_out_slot  <= r_hold_slot;
                            r_out_full  <= 1'b0;
                            r_out_kind  <= 1'b0;
                            r_out_last  <= 1'b1;
                            r_hold_v    <= 1'b0;
                        end
                    end
                end
                S_FIND: begin
                    if (r_status[r_idx] == ST_OFF) begin
                        r_slot <= r_idx;
                        r_full <= 1'b0;
                        r_rem  <= 8'd0;
                        r_quo  <= r_ival;
                        r_dcnt <= 4'd0;
                    end else if (w_last_idx) begin
                        r_slot <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DIV1: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_period <= n_quo;
                        r_rem    <= 8'd0;
                        r_quo    <= r_pdly;
                    end else begin
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                    end
                end
                S_DIV2: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_pre <= n_quo;
                    end
                end
                S_REPLY: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_slot  <= 3'(r_slot);
                        r_out_full  <= r_full;
                        r_out_kind  <= 1'b1;
                        r_out_last  <= 1'b1;
                        if (!r_full) begin
                            r_status[r_slot] <= ST_ADD;
                            r_wr[r_slot]     <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= 4'(MAX_RES))
        else $error("result count past limit");

    a_hold_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_nres != 4'd0))
        else $error("held result without count");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind) |-> r_out_last)
        else $error("add reply not final");

    a_reply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPLY && !r_full) |-> (r_status[r_slot] == ST_OFF))
        else $error("add reply on busy slot");

    a_tend_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEND && !r_hold_v) |=> (r_state == S_IDLE))
        else $error("tick end did not return to idle");

endmodule
